@@ sv/rlpfd_pkg.sv @@
`default_nettype none

package rlpfd_pkg;

   // chain size and frame tail
   localparam int LED_COUNT       = 256;
   localparam int RESET_SLOTS     = 50;
   localparam int WORDS_PER_PIXEL = 24;

   // fixed field widths
   localparam int FUNC_W  = 3;
   localparam int IDX_W   = 8;
   localparam int FCNT_W  = 9;
   localparam int COLOR_W = 24;
   localparam int CHAN_W  = 8;
   localparam int WORD_W  = 16;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 1;

   // derived widths
   localparam int PIX_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int CNT_W  = $clog2(LED_COUNT + 1);
   localparam int SUM_W  = $clog2((1 << IDX_W) + (1 << FCNT_W) + LED_COUNT);
   localparam int BIT_W  = $clog2(WORDS_PER_PIXEL);
   localparam int SLOT_W = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SET   = 3'd0,
      FUNC_FILL  = 3'd1,
      FUNC_READ  = 3'd2,
      FUNC_CLEAR = 3'd3,
      FUNC_START = 3'd4,
      FUNC_TICK  = 3'd5
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_BUSY  = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ONE_HIGH  = 1'b0,
      CSR_ZERO_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_FILL = 4'b0100,
      S_WAIT = 4'b1000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic do_set;
      logic do_clear;
      logic fill_write;
      logic rd_issue;
      logic respond;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              idx_in_range;
      logic              tick_pixel;
      logic              fill_more;
   } dp_status_type;

endpackage

`default_nettype wire

@@ sv/rlpfd_ctrl.sv @@
`default_nettype none

module rlpfd_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire rlpfd_pkg::dp_status_type sts,
   output rlpfd_pkg::ctrl_cmd_type       cmd
);

   rlpfd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlpfd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != rlpfd_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         rlpfd_pkg::S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = rlpfd_pkg::S_EXEC;
            end
         end
         rlpfd_pkg::S_EXEC: begin
            unique case (sts.func)
               rlpfd_pkg::FUNC_SET: begin
                  cmd.do_set  = 1'b1;
                  cmd.respond = 1'b1;
                  state_in    = rlpfd_pkg::S_IDLE;
               end
               rlpfd_pkg::FUNC_FILL: begin
                  state_in = rlpfd_pkg::S_FILL;
               end
               rlpfd_pkg::FUNC_READ: begin
                  if (sts.idx_in_range) begin
                     cmd.rd_issue = 1'b1;
                     state_in     = rlpfd_pkg::S_WAIT;
                  end else begin
                     cmd.respond = 1'b1;
                     state_in    = rlpfd_pkg::S_IDLE;
                  end
               end
               rlpfd_pkg::FUNC_CLEAR: begin
                  cmd.do_clear = 1'b1;
                  cmd.respond  = 1'b1;
                  state_in     = rlpfd_pkg::S_IDLE;
               end
               rlpfd_pkg::FUNC_TICK: begin
                  if (sts.tick_pixel) begin
                     cmd.rd_issue = 1'b1;
                     state_in     = rlpfd_pkg::S_WAIT;
                  end else begin
                     cmd.respond = 1'b1;
                     state_in    = rlpfd_pkg::S_IDLE;
                  end
               end
               default: begin
                  // start frame and unused codes
                  cmd.respond = 1'b1;
                  state_in    = rlpfd_pkg::S_IDLE;
               end
            endcase
         end
         rlpfd_pkg::S_FILL: begin
            if (sts.fill_more) begin
               cmd.fill_write = 1'b1;
            end else begin
               cmd.respond = 1'b1;
               state_in    = rlpfd_pkg::S_IDLE;
            end
         end
         rlpfd_pkg::S_WAIT: begin
            cmd.respond = 1'b1;
            state_in    = rlpfd_pkg::S_IDLE;
         end
         default: begin
            state_in = rlpfd_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/rlpfd_dpath.sv @@
`default_nettype none

module rlpfd_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rlpfd_pkg::ctrl_cmd_type             cmd,
   output rlpfd_pkg::dp_status_type                 sts,
   input  wire logic [rlpfd_pkg::FUNC_W-1:0]        req_func,
   input  wire logic [rlpfd_pkg::IDX_W-1:0]         req_pixel_index,
   input  wire logic [rlpfd_pkg::FCNT_W-1:0]        req_fill_count,
   input  wire logic [rlpfd_pkg::CHAN_W-1:0]        req_green_in,
   input  wire logic [rlpfd_pkg::CHAN_W-1:0]        req_red_in,
   input  wire logic [rlpfd_pkg::CHAN_W-1:0]        req_blue_in,
   input  wire logic                                csr_wr_en,
   input  wire logic [rlpfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rlpfd_pkg::WORD_W-1:0]        csr_wdata,
   output logic                                     rsp_strobe,
   output logic [rlpfd_pkg::WORD_W-1:0]             rsp_compare_word,
   output logic [rlpfd_pkg::CHAN_W-1:0]             rsp_green_out,
   output logic [rlpfd_pkg::CHAN_W-1:0]             rsp_red_out,
   output logic [rlpfd_pkg::CHAN_W-1:0]             rsp_blue_out,
   output logic                                     rsp_frame_running,
   output logic                                     rsp_frame_last,
   output logic [rlpfd_pkg::STAT_W-1:0]             rsp_status
);

   localparam int PIX_W   = rlpfd_pkg::PIX_W;
   localparam int CNT_W   = rlpfd_pkg::CNT_W;
   localparam int SUM_W   = rlpfd_pkg::SUM_W;
   localparam int BIT_W   = rlpfd_pkg::BIT_W;
   localparam int SLOT_W  = rlpfd_pkg::SLOT_W;
   localparam int COLOR_W = rlpfd_pkg::COLOR_W;
   localparam int CHAN_W  = rlpfd_pkg::CHAN_W;
   localparam int WORD_W  = rlpfd_pkg::WORD_W;

   // config registers
   logic [WORD_W-1:0] one_high_ff, zero_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         one_high_ff  <= WORD_W'(58);
         zero_high_ff <= WORD_W'(29);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rlpfd_pkg::CSR_ONE_HIGH:  one_high_ff  <= csr_wdata;
            rlpfd_pkg::CSR_ZERO_HIGH: zero_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // latched command
   logic [rlpfd_pkg::FUNC_W-1:0] func_ff;
   logic [rlpfd_pkg::IDX_W-1:0]  idx_ff;
   logic [rlpfd_pkg::FCNT_W-1:0] fcnt_ff;
   logic [COLOR_W-1:0]           color_ff;
   logic [SUM_W-1:0]             fptr_ff, fptr_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         idx_ff   <= req_pixel_index;
         fcnt_ff  <= req_fill_count;
         color_ff <= {req_green_in, req_red_in, req_blue_in};
      end
      fptr_ff <= fptr_in;
   end

   always_comb begin
      fptr_in = fptr_ff;
      if (cmd.capture) begin
         fptr_in = SUM_W'(req_pixel_index);
      end else if (cmd.fill_write) begin
         fptr_in = fptr_ff + SUM_W'(1);
      end
   end

   logic              is_set, is_fill, is_read, is_start, is_tick;
   logic [SUM_W-1:0]  idx_ext, fill_sum, fill_end;
   logic              idx_in_range, fill_over;
   logic [PIX_W-1:0]  idx_addr;

   assign is_set   = (func_ff == rlpfd_pkg::FUNC_SET);
   assign is_fill  = (func_ff == rlpfd_pkg::FUNC_FILL);
   assign is_read  = (func_ff == rlpfd_pkg::FUNC_READ);
   assign is_start = (func_ff == rlpfd_pkg::FUNC_START);
   assign is_tick  = (func_ff == rlpfd_pkg::FUNC_TICK);

   assign idx_ext      = SUM_W'(idx_ff);
   assign idx_addr     = idx_ext[PIX_W-1:0];
   assign idx_in_range = (idx_ext < SUM_W'(rlpfd_pkg::LED_COUNT));
   assign fill_sum     = idx_ext + SUM_W'(fcnt_ff);
   assign fill_over    = (fill_sum > SUM_W'(rlpfd_pkg::LED_COUNT));
   assign fill_end     = fill_over ? SUM_W'(rlpfd_pkg::LED_COUNT) : fill_sum;

   // frame position: pixel, bit within pixel, reset slot
   logic              active_ff, active_in;
   logic [CNT_W-1:0]  pix_ff, pix_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              in_pixels, frame_end;
   logic [PIX_W-1:0]  pix_addr;

   assign in_pixels = (pix_ff < CNT_W'(rlpfd_pkg::LED_COUNT));
   assign frame_end = !in_pixels && (slot_ff == SLOT_W'(rlpfd_pkg::RESET_SLOTS - 1));
   assign pix_addr  = pix_ff[PIX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pix_ff    <= '0;
         bit_ff    <= '0;
         slot_ff   <= '0;
      end else begin
         active_ff <= active_in;
         pix_ff    <= pix_in;
         bit_ff    <= bit_in;
         slot_ff   <= slot_in;
      end
   end

   always_comb begin
      active_in = active_ff;
      pix_in    = pix_ff;
      bit_in    = bit_ff;
      slot_in   = slot_ff;
      if (cmd.respond && is_start && !active_ff) begin
         active_in = 1'b1;
         pix_in    = '0;
         bit_in    = '0;
         slot_in   = '0;
      end else if (cmd.respond && is_tick && active_ff) begin
         priority if (in_pixels) begin
            if (bit_ff == BIT_W'(rlpfd_pkg::WORDS_PER_PIXEL - 1)) begin
               bit_in = '0;
               pix_in = pix_ff + CNT_W'(1);
            end else begin
               bit_in = bit_ff + BIT_W'(1);
            end
         end else if (frame_end) begin
            active_in = 1'b0;
            pix_in    = '0;
            bit_in    = '0;
            slot_in   = '0;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   // pixel store: written marks a pixel as set or cleared, color_ok says the ram holds its bits
   logic [rlpfd_pkg::LED_COUNT-1:0] written_ff, color_ok_ff;
   logic [COLOR_W-1:0]              mem [rlpfd_pkg::LED_COUNT];
   logic [COLOR_W-1:0]              rdata_ff;
   logic                            mem_we;
   logic [PIX_W-1:0]                waddr, raddr;

   assign mem_we = (cmd.do_set && idx_in_range) || cmd.fill_write;
   assign waddr  = cmd.fill_write ? fptr_ff[PIX_W-1:0] : idx_addr;
   assign raddr  = is_read ? idx_addr : pix_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= color_ff;
      end
      if (cmd.rd_issue) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff  <= '0;
         color_ok_ff <= '0;
      end else if (cmd.do_clear) begin
         written_ff  <= '1;
         color_ok_ff <= '0;
      end else if (mem_we) begin
         written_ff[waddr]  <= 1'b1;
         color_ok_ff[waddr] <= 1'b1;
      end
   end

   // result
   logic [BIT_W-1:0]  bit_sel;
   logic              bit_val;
   logic [WORD_W-1:0] word_c;
   logic [COLOR_W-1:0] rd_c;
   logic              last_c, running_c;
   rlpfd_pkg::status_type status_c;

   assign bit_sel = BIT_W'(rlpfd_pkg::WORDS_PER_PIXEL - 1) - bit_ff;
   assign bit_val = color_ok_ff[pix_addr] && rdata_ff[bit_sel];

   always_comb begin
      word_c = '0;
      if (is_tick && active_ff && in_pixels && written_ff[pix_addr]) begin
         word_c = bit_val ? one_high_ff : zero_high_ff;
      end
      rd_c = '0;
      if (is_read && idx_in_range && color_ok_ff[idx_addr]) begin
         rd_c = rdata_ff;
      end
      last_c    = is_tick && active_ff && frame_end;
      running_c = is_start || active_ff;
      status_c  = rlpfd_pkg::STAT_OK;
      if ((is_set || is_read) && !idx_in_range) begin
         status_c = rlpfd_pkg::STAT_RANGE;
      end else if (is_fill && fill_over) begin
         status_c = rlpfd_pkg::STAT_RANGE;
      end else if (is_start && active_ff) begin
         status_c = rlpfd_pkg::STAT_BUSY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_compare_word  <= word_c;
         rsp_green_out     <= rd_c[3*CHAN_W-1:2*CHAN_W];
         rsp_red_out       <= rd_c[2*CHAN_W-1:CHAN_W];
         rsp_blue_out      <= rd_c[CHAN_W-1:0];
         rsp_frame_running <= running_c;
         rsp_frame_last    <= last_c;
         rsp_status        <= status_c;
      end
   end

   assign sts.func         = func_ff;
   assign sts.idx_in_range = idx_in_range;
   assign sts.tick_pixel   = active_ff && in_pixels;
   assign sts.fill_more    = (fptr_ff < fill_end);

endmodule

`default_nettype wire

@@ sv/rgb_led_pulse_frame_driver.sv @@
`default_nettype none

// Pixel store and pulse-word sequencer for a chain of one-wire RGB LEDs. Pulse start with
// a command on the req_ ports while busy is low; exactly one result comes back for every
// command as a one-cycle rsp_strobe, and the receiver cannot hold it off, so it must
// capture the rsp_ ports whenever the strobe is high. Busy drops in the strobe cycle,
// so the next command may be issued alongside it. Set pixel, clear all, start frame, idle
// tick, out-of-range read and unused codes pass through the execute state only; read
// pixel and a tick inside the pixel part of a frame add a wait state, because the
// 24-bit pixel RAM has a registered read port; a fill of N pixels makes one RAM write
// per cycle. Clear all touches no RAM word: per-pixel written and color-valid flags
// stand in for the RAM contents, so no clearing pass is needed after reset either.
// While a frame runs, each tick returns the next compare word (green, red, blue, msb
// first), then the reset-slot zeros, with frame_last on the final word. Compare
// registers are written on the csr_ port at any edge with csr_wr_en high, index 0 for
// the one-bit count and 1 for the zero-bit count.
module rgb_led_pulse_frame_driver (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // command channel
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [rlpfd_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [rlpfd_pkg::IDX_W-1:0]      req_pixel_index,
   input  wire logic [rlpfd_pkg::FCNT_W-1:0]     req_fill_count,
   input  wire logic [rlpfd_pkg::CHAN_W-1:0]     req_green_in,
   input  wire logic [rlpfd_pkg::CHAN_W-1:0]     req_red_in,
   input  wire logic [rlpfd_pkg::CHAN_W-1:0]     req_blue_in,
   // result channel
   output logic                                  rsp_strobe,
   output logic [rlpfd_pkg::WORD_W-1:0]          rsp_compare_word,
   output logic [rlpfd_pkg::CHAN_W-1:0]          rsp_green_out,
   output logic [rlpfd_pkg::CHAN_W-1:0]          rsp_red_out,
   output logic [rlpfd_pkg::CHAN_W-1:0]          rsp_blue_out,
   output logic                                  rsp_frame_running,
   output logic                                  rsp_frame_last,
   output logic [rlpfd_pkg::STAT_W-1:0]          rsp_status,
   // register writes
   input  wire logic                             csr_wr_en,
   input  wire logic [rlpfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rlpfd_pkg::WORD_W-1:0]     csr_wdata
);

   // command and status between sequencer and datapath
   rlpfd_pkg::ctrl_cmd_type  cmd;
   rlpfd_pkg::dp_status_type sts;

   // sequencer: accepts an item, steps through execute, fill walk or ram read wait
   rlpfd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath: pixel ram and flags, frame counters, compare registers, result registers
   rlpfd_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_pixel_index   (req_pixel_index),
      .req_fill_count    (req_fill_count),
      .req_green_in      (req_green_in),
      .req_red_in        (req_red_in),
      .req_blue_in       (req_blue_in),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_strobe        (rsp_strobe),
      .rsp_compare_word  (rsp_compare_word),
      .rsp_green_out     (rsp_green_out),
      .rsp_red_out       (rsp_red_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_frame_running (rsp_frame_running),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_status        (rsp_status)
   );

`ifndef SYNTHESIS
   // a result only follows a command in progress
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a command in progress");

   // an accepted command always occupies the sequencer next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted command neither busy nor answered");

   // final word of a frame is only reported while the frame runs
   a_last_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_frame_last) |-> rsp_frame_running)
      else $error("frame_last outside a running frame");

   // a refused start leaves the frame running
   a_busy_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == rlpfd_pkg::STAT_BUSY)) |-> rsp_frame_running)
      else $error("busy status without a running frame");
`endif

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// package values used below
localparam int LED_COUNT       = rlpfd_pkg::LED_COUNT;
localparam int RESET_SLOTS     = rlpfd_pkg::RESET_SLOTS;
localparam int WORDS_PER_PIXEL = rlpfd_pkg::WORDS_PER_PIXEL;
localparam int FUNC_W          = rlpfd_pkg::FUNC_W;
localparam int IDX_W           = rlpfd_pkg::IDX_W;
localparam int FCNT_W          = rlpfd_pkg::FCNT_W;
localparam int COLOR_W         = rlpfd_pkg::COLOR_W;
localparam int CHAN_W          = rlpfd_pkg::CHAN_W;
localparam int WORD_W          = rlpfd_pkg::WORD_W;
localparam int STAT_W          = rlpfd_pkg::STAT_W;
localparam int CSR_IDX_W       = rlpfd_pkg::CSR_IDX_W;

// spare opcodes the block must treat as no-ops
localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

localparam int PIXEL_WORDS = LED_COUNT * WORDS_PER_PIXEL;
localparam int FRAME_WORDS = PIXEL_WORDS + RESET_SLOTS;

typedef struct packed {
   logic [FUNC_W-1:0] func;
   logic [IDX_W-1:0]  pixel_index;
   logic [FCNT_W-1:0] fill_count;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] blue;
} led_command_type;

typedef struct packed {
   logic [WORD_W-1:0] compare_word;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] blue;
   logic              running;
   logic              last;
   logic [STAT_W-1:0] status;
} led_result_type;

class led_frame_scoreboard;
   logic [COLOR_W-1:0] color [LED_COUNT];
   bit                 written [LED_COUNT];
   int unsigned        position;
   bit                 frame_on;
   logic [WORD_W-1:0]  one_count;
   logic [WORD_W-1:0]  zero_count;
   led_result_type     owed_results [$];
   int unsigned        items_noted, results_seen, mismatches;
   int unsigned        frames_done, clipped, refused_starts;

   function new();
      for (int i = 0; i < LED_COUNT; i++) begin
         color[i]   = '0;
         written[i] = 1'b0;
      end
      position   = 0;
      frame_on   = 1'b0;
      one_count  = 16'd58;
      zero_count = 16'd29;
   endfunction

   function void set_reg(rlpfd_pkg::csr_index_type which, logic [WORD_W-1:0] value);
      if (which == rlpfd_pkg::CSR_ONE_HIGH) one_count = value;
      else zero_count = value;
   endfunction

   function void store(int unsigned px, logic [COLOR_W-1:0] grb);
      color[px]   = grb;
      written[px] = 1'b1;
   endfunction

   // compare word for one slot of the frame
   function logic [WORD_W-1:0] slot_word(int unsigned pos);
      int unsigned px;
      int unsigned bit_pos;
      if (pos >= PIXEL_WORDS) return '0;
      px      = pos / WORDS_PER_PIXEL;
      bit_pos = pos % WORDS_PER_PIXEL;
      if (!written[px]) return '0;
      return color[px][23 - bit_pos] ? one_count : zero_count;
   endfunction

   function void note_command(led_command_type cmd);
      led_result_type     res;
      logic [COLOR_W-1:0] grb;
      int unsigned        stop;
      res = '0;
      grb = {cmd.green, cmd.red, cmd.blue};
      items_noted++;
      case (cmd.func)
         rlpfd_pkg::FUNC_SET: begin
            if (cmd.pixel_index < LED_COUNT) store(32'(cmd.pixel_index), grb);
            else res.status = rlpfd_pkg::STAT_RANGE;
         end
         rlpfd_pkg::FUNC_FILL: begin
            stop = 32'(cmd.pixel_index) + 32'(cmd.fill_count);
            if (stop > LED_COUNT) begin
               res.status = rlpfd_pkg::STAT_RANGE;
               stop = LED_COUNT;
            end
            for (int unsigned i = 32'(cmd.pixel_index); i < stop; i++) store(i, grb);
         end
         rlpfd_pkg::FUNC_READ: begin
            if (cmd.pixel_index < LED_COUNT)
               {res.green, res.red, res.blue} = color[cmd.pixel_index];
            else res.status = rlpfd_pkg::STAT_RANGE;
         end
         rlpfd_pkg::FUNC_CLEAR: begin
            for (int unsigned i = 0; i < LED_COUNT; i++) store(i, '0);
         end
         rlpfd_pkg::FUNC_START: begin
            if (frame_on) begin
               res.status = rlpfd_pkg::STAT_BUSY;
               refused_starts++;
            end else begin
               frame_on = 1'b1;
               position = 0;
            end
         end
         default: ;
      endcase
      res.running = frame_on;
      if (cmd.func == rlpfd_pkg::FUNC_TICK && frame_on) begin
         res.compare_word = slot_word(position);
         position++;
         if (position >= FRAME_WORDS) begin
            res.last = 1'b1;
            frame_on = 1'b0;
            position = 0;
            frames_done++;
         end
      end
      if (res.status == rlpfd_pkg::STAT_RANGE) clipped++;
      owed_results.push_back(res);
   endfunction

   function void check_result(led_result_type got);
      led_result_type want;
      results_seen++;
      if (owed_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d arrived with nothing owed: word=%h status=%0d",
                     results_seen, got.compare_word, got.status);
         return;
      end
      want = owed_results.pop_front();
      if (got.compare_word !== want.compare_word || got.green !== want.green ||
          got.red !== want.red || got.blue !== want.blue ||
          got.running !== want.running || got.last !== want.last ||
          got.status !== want.status) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on result %0d", results_seen);
            $display("  expected word=%h g=%h r=%h b=%h run=%b last=%b status=%0d",
                     want.compare_word, want.green, want.red, want.blue,
                     want.running, want.last, want.status);
            $display("  actual   word=%h g=%h r=%h b=%h run=%b last=%b status=%0d",
                     got.compare_word, got.green, got.red, got.blue,
                     got.running, got.last, got.status);
         end
      end
   endfunction

   function int pending();
      return owed_results.size();
   endfunction
endclass

module tb;

   // far above the longest run, even with every fill at full length
   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // command channel
   logic               start           = 1'b0;
   logic               busy;
   logic [FUNC_W-1:0]  req_func        = '0;
   logic [IDX_W-1:0]   req_pixel_index = '0;
   logic [FCNT_W-1:0]  req_fill_count  = '0;
   logic [CHAN_W-1:0]  req_green_in    = '0;
   logic [CHAN_W-1:0]  req_red_in      = '0;
   logic [CHAN_W-1:0]  req_blue_in     = '0;

   // result channel
   logic               rsp_strobe;
   logic [WORD_W-1:0]  rsp_compare_word;
   logic [CHAN_W-1:0]  rsp_green_out;
   logic [CHAN_W-1:0]  rsp_red_out;
   logic [CHAN_W-1:0]  rsp_blue_out;
   logic               rsp_frame_running;
   logic               rsp_frame_last;
   logic [STAT_W-1:0]  rsp_status;

   // register port
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   led_frame_scoreboard sb;
   bit                  idle_on = 1'b1;
   int unsigned         cycle_count = 0;

   rgb_led_pulse_frame_driver uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_pixel_index   (req_pixel_index),
      .req_fill_count    (req_fill_count),
      .req_green_in      (req_green_in),
      .req_red_in        (req_red_in),
      .req_blue_in       (req_blue_in),
      .rsp_strobe        (rsp_strobe),
      .rsp_compare_word  (rsp_compare_word),
      .rsp_green_out     (rsp_green_out),
      .rsp_red_out       (rsp_red_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_frame_running (rsp_frame_running),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_status        (rsp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 12 time unit clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog, a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // results cannot be held off, so take every strobe as it comes
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_result('{rsp_compare_word, rsp_green_out, rsp_red_out, rsp_blue_out,
                           rsp_frame_running, rsp_frame_last, rsp_status});
   end

   function automatic led_command_type make_cmd(logic [FUNC_W-1:0] func,
                                                logic [IDX_W-1:0] idx,
                                                logic [FCNT_W-1:0] cnt,
                                                logic [COLOR_W-1:0] grb);
      return '{func, idx, cnt, grb[23:16], grb[15:8], grb[7:0]};
   endfunction

   // random payload around a given opcode; fills are mostly short so the
   // pixel walk stays cheap, with the odd long or clipped one
   function automatic led_command_type random_fields(logic [FUNC_W-1:0] func);
      led_command_type cmd;
      int unsigned     pick;
      pick = $urandom_range(9);
      cmd.func        = func;
      cmd.pixel_index = IDX_W'($urandom_range(255));
      if (pick < 7) cmd.fill_count = FCNT_W'($urandom_range(12));
      else if (pick < 9) cmd.fill_count = FCNT_W'($urandom_range(LED_COUNT));
      else cmd.fill_count = FCNT_W'($urandom_range(511));
      cmd.green = CHAN_W'($urandom_range(255));
      cmd.red   = CHAN_W'($urandom_range(255));
      cmd.blue  = CHAN_W'($urandom_range(255));
      return cmd;
   endfunction

   // present one item and hold it until the block takes it
   task automatic issue(input led_command_type cmd);
      @(negedge clock);
      // random idle cycles ahead of the item
      while (idle_on && $urandom_range(99) < 28) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start           <= 1'b1;
      req_func        <= cmd.func;
      req_pixel_index <= cmd.pixel_index;
      req_fill_count  <= cmd.fill_count;
      req_green_in    <= cmd.green;
      req_red_in      <= cmd.red;
      req_blue_in     <= cmd.blue;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_command(cmd);
   endtask

   // stop issuing and wait for every owed result
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input rlpfd_pkg::csr_index_type which,
                            input logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_reg(which, value);
   endtask

   // tick a frame along for a given number of items, with a sprinkle of
   // pixel traffic right around the word being sent and refused restarts
   task automatic run_frame(input bit swap_midway, input int unsigned budget);
      led_command_type cmd;
      int unsigned     pick;
      int unsigned     sent;
      bit              swapped;
      swapped = 1'b0;
      sent    = 0;
      if (!sb.frame_on) begin
         issue(random_fields(rlpfd_pkg::FUNC_START));
         sent++;
      end
      while (sb.frame_on && sent < budget) begin
         if (swap_midway && !swapped && sent >= budget / 2) begin
            // flip the pulse widths halfway through
            settle();
            write_reg(rlpfd_pkg::CSR_ONE_HIGH, 16'h0000);
            write_reg(rlpfd_pkg::CSR_ZERO_HIGH, 16'hFFFF);
            swapped = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 4) begin
            if (pick < 2) cmd = random_fields(rlpfd_pkg::FUNC_SET);
            else if (pick < 3) cmd = random_fields(rlpfd_pkg::FUNC_FILL);
            else cmd = random_fields(rlpfd_pkg::FUNC_READ);
            cmd.pixel_index = IDX_W'(sb.position / WORDS_PER_PIXEL + $urandom_range(2));
            issue(cmd);
         end else if (pick < 5) begin
            issue(random_fields(rlpfd_pkg::FUNC_START));
         end else begin
            issue(random_fields(rlpfd_pkg::FUNC_TICK));
         end
         sent++;
      end
   endtask

   initial begin
      int unsigned pick;
      logic [FUNC_W-1:0] func;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset pulse widths
      issue(make_cmd(rlpfd_pkg::FUNC_READ, 8'd1, 9'd0, 24'h000000)); // never written
      issue(make_cmd(rlpfd_pkg::FUNC_TICK, 8'd0, 9'd0, 24'hFFFFFF)); // tick with no frame
      issue(make_cmd(rlpfd_pkg::FUNC_SET, 8'd0, 9'd0, 24'hA53CFF));
      issue(make_cmd(rlpfd_pkg::FUNC_SET, 8'd255, 9'd0, 24'hFFFFFF));
      issue(make_cmd(rlpfd_pkg::FUNC_SET, 8'd200, 9'd0, 24'h000000)); // written black
      issue(make_cmd(rlpfd_pkg::FUNC_READ, 8'd0, 9'd0, 24'h000000));
      issue(make_cmd(rlpfd_pkg::FUNC_READ, 8'd255, 9'd0, 24'h000000));
      issue(make_cmd(rlpfd_pkg::FUNC_FILL, 8'd20, 9'd0, 24'h123456)); // empty fill
      // ends right at the chain end
      issue(make_cmd(rlpfd_pkg::FUNC_FILL, 8'd96, 9'd160, 24'h0F0F0F));
      issue(make_cmd(rlpfd_pkg::FUNC_FILL, 8'd250, 9'd4, 24'h5AC30F));
      issue(make_cmd(rlpfd_pkg::FUNC_FILL, 8'd252, 9'd511, 24'h814224)); // clipped
      issue(make_cmd(rlpfd_pkg::FUNC_READ, 8'd253, 9'd0, 24'h000000));
      issue(make_cmd(FUNC_SPARE_A, 8'hFF, 9'h1FF, 24'hFFFFFF));
      issue(make_cmd(FUNC_SPARE_B, 8'hFF, 9'h1FF, 24'hFFFFFF));

      // widest pulse-width spread for the first frame
      settle();
      write_reg(rlpfd_pkg::CSR_ONE_HIGH, 16'hFFFF);
      write_reg(rlpfd_pkg::CSR_ZERO_HIGH, 16'h0000);
      issue(make_cmd(rlpfd_pkg::FUNC_START, 8'd0, 9'd0, 24'h000000));
      // refused while sending
      issue(make_cmd(rlpfd_pkg::FUNC_START, 8'd0, 9'd0, 24'h000000));
      issue(make_cmd(rlpfd_pkg::FUNC_READ, 8'd0, 9'd0, 24'h000000));
      issue(make_cmd(FUNC_SPARE_A, 8'd0, 9'd0, 24'h000000));
      run_frame(1'b1, 60);
      issue(make_cmd(rlpfd_pkg::FUNC_CLEAR, 8'hA5, 9'h0AA, 24'h5A5A5A));
      issue(make_cmd(rlpfd_pkg::FUNC_READ, 8'd0, 9'd0, 24'h000000));
      issue(make_cmd(rlpfd_pkg::FUNC_TICK, 8'd0, 9'd0, 24'h000000));

      // random part in three chunks, each with its own pulse widths;
      // the middle chunk runs with no idle cycles at all
      for (int chunk = 0; chunk < 3; chunk++) begin
         settle();
         if (chunk == 1) begin
            pick = $urandom_range(16'hFFFF);
            write_reg(rlpfd_pkg::CSR_ONE_HIGH, WORD_W'(pick));
            write_reg(rlpfd_pkg::CSR_ZERO_HIGH, WORD_W'(pick));
         end else begin
            write_reg(rlpfd_pkg::CSR_ONE_HIGH, WORD_W'($urandom_range(16'hFFFF)));
            write_reg(rlpfd_pkg::CSR_ZERO_HIGH, WORD_W'($urandom_range(16'hFFFF)));
         end
         idle_on = (chunk != 1);
         repeat (120) begin
            pick = $urandom_range(99);
            if (pick < 14) func = rlpfd_pkg::FUNC_SET;
            else if (pick < 24) func = rlpfd_pkg::FUNC_FILL;
            else if (pick < 38) func = rlpfd_pkg::FUNC_READ;
            else if (pick < 41) func = rlpfd_pkg::FUNC_CLEAR;
            else if (pick < 48) func = rlpfd_pkg::FUNC_START;
            else if (pick < 96) func = rlpfd_pkg::FUNC_TICK;
            else if (pick < 98) func = FUNC_SPARE_A;
            else func = FUNC_SPARE_B;
            issue(random_fields(func));
         end
      end

      // back to the reset widths and a few more frame words around random pixels
      settle();
      write_reg(rlpfd_pkg::CSR_ONE_HIGH, 16'd58);
      write_reg(rlpfd_pkg::CSR_ZERO_HIGH, 16'd29);
      idle_on = 1'b1;
      run_frame(1'b0, 20);

      // drain and let any stray strobe show up
      settle();
      repeat (10) @(posedge clock);
      $display("summary: %0d items, %0d results, %0d frames sent to the last word",
               sb.items_noted, sb.results_seen, sb.frames_done);
      $display("summary: %0d clipped commands, %0d refused starts, %0d mismatches",
               sb.clipped, sb.refused_starts, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/rlpfd_pkg.sv
sv/rlpfd_ctrl.sv
sv/rlpfd_dpath.sv
sv/rgb_led_pulse_frame_driver.sv
dv/tb.sv
